### rtl/dmht_pkg.sv
// ============================================================================
// dmht_pkg: shared types and constants of the direct-mapped hash table
// Item layouts, request and status codes, default sizes and divider shape.
// ============================================================================
package dmht_pkg;

    // Fixed field widths of the items
    localparam int KEY_BITS  = 32;
    localparam int VALUE_W   = 32;
    localparam int SIZE_BITS = 11;

    // Defaults for the top-level parameters
    localparam int MAX_SLOTS_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // Table size after reset
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 11'd1024;

    // Sign bit cleared before hashing
    localparam logic [KEY_BITS-1:0] KEY_MAG_MASK = 32'h7FFF_FFFF;

    // Remainder unit: quotient bits retired per cycle and steps per key
    localparam int DIV_DIGIT_BITS = 4;
    localparam int DIV_STEPS      = KEY_BITS / DIV_DIGIT_BITS;

    // Entries in the queue between classifier and slot engine
    localparam int QUEUE_DEPTH = 2;

    // Request kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REFUSED  = 2'd1;
    localparam logic [1:0] ST_HIT      = 2'd2;
    localparam logic [1:0] ST_MISS     = 2'd3;

    typedef struct packed {
        logic                       kind;
        logic signed [KEY_BITS-1:0] key;
        logic [VALUE_W-1:0]         entry_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [VALUE_W-1:0]   read_value;
        logic [SIZE_BITS-1:0] stored_count;
    } out_item_t;

endpackage

### rtl/dmht_ram.sv
// ============================================================================
// dmht_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ============================================================================
module dmht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dmht_queue.sv
// ============================================================================
// dmht_queue: short FIFO between classifier and slot engine
// Register-based, QUEUE_DEPTH entries, full and empty flags.
// ============================================================================
module dmht_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    import dmht_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    entries_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/dmht_front.sv
// ============================================================================
// dmht_front: request classifier
// Accepts an item, reduces the masked key modulo the table size four
// quotient bits a cycle, and pushes kind, slot index and value to the queue.
// ============================================================================
module dmht_front #(
    parameter int MAX_SLOTS = dmht_pkg::MAX_SLOTS_DEF,
    localparam int IDX_BITS   = $clog2(MAX_SLOTS),
    localparam int ENTRY_BITS = 1 + IDX_BITS + dmht_pkg::VALUE_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  dmht_pkg::in_item_t             in_item,
    input  logic [dmht_pkg::SIZE_BITS-1:0] eff_size,
    input  logic                           clear_busy,
    output logic                           push,
    output logic [ENTRY_BITS-1:0]          push_data,
    input  logic                           q_full
);
    import dmht_pkg::*;

    localparam int STEP_BITS = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

    fstate_t              state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [KEY_BITS-1:0]  dvd_reg, dvd_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next;
    logic                 kind_reg, kind_next;
    logic [VALUE_W-1:0]   value_reg, value_next;

    logic [SIZE_BITS:0]   part;
    logic [SIZE_BITS:0]   divisor;
    logic [31:0]          rem_wide;
    logic [IDX_BITS-1:0]  idx;
    logic                 accept;

    assign in_stall = (state_reg != F_IDLE) || clear_busy;
    assign accept   = in_valid && !in_stall;
    assign divisor  = {1'b0, eff_size};

    // Restoring remainder, DIV_DIGIT_BITS quotient bits per cycle
    always_comb
    begin
        part = {1'b0, rem_reg};
        for (int i = 0; i < DIV_DIGIT_BITS; i++)
        begin
            part = {part[SIZE_BITS-1:0], dvd_reg[KEY_BITS-1-i]};
            if (part >= divisor)
            begin
                part = part - divisor;
            end
        end
    end

    assign rem_wide  = {{(32 - SIZE_BITS){1'b0}}, rem_reg};
    assign idx       = rem_wide[IDX_BITS-1:0];
    assign push      = (state_reg == F_PUSH);
    assign push_data = {kind_reg, idx, value_reg};

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    dvd_next   = in_item.key & KEY_MAG_MASK;
                    rem_next   = '0;
                    step_next  = '0;
                    kind_next  = in_item.kind;
                    value_next = in_item.entry_value;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                rem_next  = part[SIZE_BITS-1:0];
                dvd_next  = dvd_reg << DIV_DIGIT_BITS;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(DIV_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
            dvd_reg   <= '0;
            rem_reg   <= '0;
            kind_reg  <= KIND_INSERT;
            value_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            dvd_reg   <= dvd_next;
            rem_reg   <= rem_next;
            kind_reg  <= kind_next;
            value_reg <= value_next;
        end
    end

endmodule

### rtl/dmht_back.sv
// ============================================================================
// dmht_back: slot engine
// Clears the slot memory after reset, then executes queued inserts and
// lookups against it and holds each result until it is taken.
// ============================================================================
module dmht_back #(
    parameter int MAX_SLOTS  = dmht_pkg::MAX_SLOTS_DEF,
    parameter int VALUE_BITS = dmht_pkg::VALUE_BITS_DEF,
    localparam int IDX_BITS   = $clog2(MAX_SLOTS),
    localparam int ENTRY_BITS = 1 + IDX_BITS + dmht_pkg::VALUE_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [dmht_pkg::SIZE_BITS-1:0] eff_size,
    input  logic                           q_empty,
    input  logic [ENTRY_BITS-1:0]          q_data,
    output logic                           pop,
    output logic                           clear_busy,
    output logic                           out_valid,
    input  logic                           out_stall,
    output dmht_pkg::out_item_t            out_item
);
    import dmht_pkg::*;

    typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_WAIT} bstate_t;

    bstate_t              state_reg, state_next;
    logic [IDX_BITS-1:0]  clr_addr_reg, clr_addr_next;
    logic [SIZE_BITS-1:0] count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;

    logic                 q_kind;
    logic [IDX_BITS-1:0]  q_idx;
    logic [VALUE_W-1:0]   q_value;
    logic [63:0]          wr_wide;
    logic [63:0]          rd_wide;
    logic                 out_free;

    logic                 ram_we;
    logic [IDX_BITS-1:0]  ram_addr;
    logic [VALUE_BITS:0]  ram_wdata;
    logic [VALUE_BITS:0]  ram_rdata;

    assign q_kind  = q_data[ENTRY_BITS-1];
    assign q_idx   = q_data[VALUE_W +: IDX_BITS];
    assign q_value = q_data[VALUE_W-1:0];

    // Keep the low VALUE_BITS bits on the way in, zero-extend on the way out
    assign wr_wide = {32'b0, q_value};
    always_comb
    begin
        rd_wide                   = '0;
        rd_wide[VALUE_BITS-1:0]   = ram_rdata[VALUE_BITS-1:0];
    end

    assign out_free   = !out_valid_reg || !out_stall;
    assign clear_busy = (state_reg == B_CLEAR);
    assign pop        = (state_reg == B_IDLE) && !q_empty && out_free;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        ram_we         = 1'b0;
        ram_addr       = q_idx;
        ram_wdata      = {1'b1, wr_wide[VALUE_BITS-1:0]};
        unique case (state_reg)
            B_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_addr      = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == IDX_BITS'(MAX_SLOTS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop)
                begin
                    if (q_kind == KIND_INSERT)
                    begin
                        out_valid_next          = 1'b1;
                        out_item_next.read_value = '0;
                        if (count_reg < eff_size)
                        begin
                            ram_we                     = 1'b1;
                            count_next                 = count_reg + 1'b1;
                            out_item_next.status       = ST_INSERTED;
                            out_item_next.stored_count = count_reg + 1'b1;
                        end
                        else
                        begin
                            out_item_next.status       = ST_REFUSED;
                            out_item_next.stored_count = count_reg;
                        end
                    end
                    else
                    begin
                        state_next = B_WAIT;
                    end
                end
            end
            B_WAIT:
            begin
                out_valid_next             = 1'b1;
                out_item_next.stored_count = count_reg;
                if (ram_rdata[VALUE_BITS])
                begin
                    out_item_next.status     = ST_HIT;
                    out_item_next.read_value = rd_wide[VALUE_W-1:0];
                end
                else
                begin
                    out_item_next.status     = ST_MISS;
                    out_item_next.read_value = '0;
                end
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    dmht_ram #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### rtl/direct_mapped_hash_table.sv
// Order: an insert's result is registered as its queue entry is popped; a lookup's
//   result waits in a further state for the slot read. A new item is taken only after
//   the last has passed the remainder unit (4 quotient bits per step over the 31-bit key magnitude) and the queue push.
// Reset: rst_n is asynchronous, active low; afterwards the slot memory is swept clear, all
//   MAX_SLOTS slots (1024 by default), with in_stall high; table_size returns to 1024.
// ============================================================================
// direct_mapped_hash_table: hash table without collision handling
// Division-method slot index, insert with a fill limit, lookup without key
// compare. Classifier and slot engine are decoupled by a short queue.
// ============================================================================
module direct_mapped_hash_table #(
    parameter int MAX_SLOTS  = dmht_pkg::MAX_SLOTS_DEF,
    parameter int VALUE_BITS = dmht_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  dmht_pkg::in_item_t             in_item,
    // Result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output dmht_pkg::out_item_t            out_item,
    // Table size register
    input  logic                           cfg_we,
    input  logic [dmht_pkg::SIZE_BITS-1:0] cfg_wdata
);
    import dmht_pkg::*;

    localparam int IDX_BITS   = $clog2(MAX_SLOTS);
    localparam int ENTRY_BITS = 1 + IDX_BITS + VALUE_W;

    logic [SIZE_BITS-1:0]  table_size_reg;
    logic [SIZE_BITS-1:0]  eff_size;

    logic                  push;
    logic [ENTRY_BITS-1:0] push_data;
    logic                  q_full;
    logic                  pop;
    logic [ENTRY_BITS-1:0] q_data;
    logic                  q_empty;
    logic                  clear_busy;

    // Table size register; the user must write it only while the block is idle, the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            table_size_reg <= cfg_wdata;
        end
    end

    // Clamp the size: zero acts as one, anything past the slot count acts as the slot count.
    // The same value is the divisor of the hash and the limit on accepted inserts.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            eff_size = SIZE_BITS'(1);
        end
        else if (32'(table_size_reg) > MAX_SLOTS)
        begin
            eff_size = SIZE_BITS'(MAX_SLOTS);
        end
        else
        begin
            eff_size = table_size_reg;
        end
    end

    // Front: accept the item, reduce the key to a slot index, hand it on
    dmht_front #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .eff_size   (eff_size),
        .clear_busy (clear_busy),
        .push       (push),
        .push_data  (push_data),
        .q_full     (q_full)
    );

    // Queue: lets the classifier finish the next key while the engine waits on the result side
    dmht_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // Back: sweep the slot memory after reset, then execute inserts and lookups in order
    dmht_back #(
        .MAX_SLOTS  (MAX_SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .eff_size   (eff_size),
        .q_empty    (q_empty),
        .q_data     (q_data),
        .pop        (pop),
        .clear_busy (clear_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

### rtl/dmht_checker.sv
// ============================================================================
// dmht_checker: port-level checks of the hash table
// Result hold under stall, count bookkeeping and read value cleanup.
// ============================================================================
module dmht_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input dmht_pkg::out_item_t out_item
);
    import dmht_pkg::*;

    logic [SIZE_BITS-1:0] last_count_reg;
    logic [SIZE_BITS-1:0] expected_count;
    logic                 is_insert;

    // Track the count carried by the last delivered item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            last_count_reg <= out_item.stored_count;
        end
    end

    assign is_insert      = (out_item.status == ST_INSERTED);
    assign expected_count = last_count_reg + {{(SIZE_BITS - 1){1'b0}}, is_insert};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result item changed or dropped while stalled");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.stored_count == expected_count)
        else $error("stored count does not follow the delivered results");

    a_value_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != ST_HIT |-> out_item.read_value == '0)
        else $error("read value not zero outside a lookup hit");

endmodule

bind direct_mapped_hash_table dmht_checker u_dmht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

### test/direct_mapped_hash_table_test.sv
`timescale 1ns / 100ps
// ============================================================================
// direct_mapped_hash_table_test: self-checking bench for the hash table
// Drives insert and lookup items through the valid/stall request channel,
// mirrors the slot table, fill count and table size in a tracker class, and
// compares every result item field by field in order. Table size is changed
// between phases while the block is idle, from zero up to past the top.
// ============================================================================
module direct_mapped_hash_table_test;
    import dmht_pkg::*;

    // Cycles with no item moving on either channel before the run is abandoned.
    // Covers the post-reset sweep, the longest stall and gap, and the latency.
    localparam int QUIET_LIMIT = 8000;
    // Cycles to hold after the last expected result before a size write, a mid-run resume or the end
    localparam int SETTLE_CYCLES = 16;
    localparam int POOL_DEPTH = 64;

    // ------------------------------------------------------------------------
    // Mirror of the table: slot contents, occupied marks, fill count and size.
    // Predicts one result per accepted request and checks results in order.
    // ------------------------------------------------------------------------
    class slot_table_tracker;
        bit                 slot_used [MAX_SLOTS_DEF];
        logic [VALUE_W-1:0] slot_data [MAX_SLOTS_DEF];
        int unsigned        fill;
        logic [SIZE_BITS-1:0] size_reg;
        out_item_t          pending_replies [$];
        int                 failures;

        function new();
            fill     = 0;
            size_reg = SIZE_RESET;
            failures = 0;
            foreach (slot_used[i])
            begin
                slot_used[i] = 1'b0;
                slot_data[i] = '0;
            end
        endfunction

        function void set_size(logic [SIZE_BITS-1:0] v);
            size_reg = v;
        endfunction

        // Clamp to 1..MAX_SLOTS; the same value divides the key and caps the fill
        function int unsigned live_size();
            if (size_reg == 0)
                return 1;
            if (size_reg > MAX_SLOTS_DEF)
                return MAX_SLOTS_DEF;
            return 32'(size_reg);
        endfunction

        function void note_request(in_item_t req);
            int unsigned        span;
            logic [KEY_BITS-1:0] mag;
            int unsigned        slot;
            out_item_t          rep;
            span = live_size();
            mag  = req.key & KEY_MAG_MASK;
            slot = mag % span;
            rep  = '0;
            if (req.kind == KIND_INSERT)
            begin
                // Replacing an occupied slot still counts toward the fill limit
                if (fill < span)
                begin
                    slot_data[slot] = req.entry_value;
                    slot_used[slot] = 1'b1;
                    fill++;
                    rep.status = ST_INSERTED;
                end
                else
                    rep.status = ST_REFUSED;
            end
            else if (slot_used[slot])
            begin
                rep.status     = ST_HIT;
                rep.read_value = slot_data[slot];
            end
            else
                rep.status = ST_MISS;
            rep.stored_count = fill[SIZE_BITS-1:0];
            pending_replies.push_back(rep);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_replies.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected result status %0d value %h count %0d",
                             $realtime, got.status, got.read_value, got.stored_count);
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.stored_count !== want.stored_count)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch status %0d/%0d value %h/%h count %0d/%0d (exp/got)",
                             $realtime, want.status, got.status, want.read_value,
                             got.read_value, want.stored_count, got.stored_count);
            end
        endfunction

        function int pending_count();
            return pending_replies.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_item;
    logic                 cfg_we;
    logic [SIZE_BITS-1:0] cfg_wdata;

    slot_table_tracker tracker = new();

    // Recently inserted keys, reused so lookups hit and same-slot items follow
    logic [KEY_BITS-1:0] key_pool [$];
    logic [KEY_BITS-1:0] last_key;
    int unsigned         quiet_cycles;

    direct_mapped_hash_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check every result item taken at a rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(out_item);
    end

    // Abandon the run once nothing has moved for too long
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver back-pressure: long free runs, short stalls, now and then a long one
    initial
    begin
        int unsigned pick;
        int unsigned span;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                out_stall = 1'b0;
                span = $urandom_range(1, 20);
            end
            else if (pick < 95)
            begin
                out_stall = 1'b1;
                span = $urandom_range(1, 3);
            end
            else
            begin
                out_stall = 1'b1;
                span = $urandom_range(10, 40);
            end
            repeat (span - 1) @(negedge clk);
        end
    end

    function automatic in_item_t make_request(logic kind, logic [31:0] key, logic [31:0] val);
        in_item_t req;
        req.kind        = kind;
        req.key         = key;
        req.entry_value = val;
        return req;
    endfunction

    // Present one item at the falling edge and hold it until it is taken
    task automatic push_request(in_item_t req);
        @(negedge clk);
        in_valid = 1'b1;
        in_item  = req;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_request(req);
        last_key = req.key;
        if (req.kind == KIND_INSERT)
        begin
            key_pool.push_back(req.key);
            if (key_pool.size() > POOL_DEPTH)
                void'(key_pool.pop_front());
        end
    endtask

    // Drop valid for a while: usually not at all, mostly briefly, rarely long
    task automatic sender_gap();
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return;
        span = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        @(negedge clk);
        in_valid            = 1'b0;
        in_item.kind        = 1'($urandom);
        in_item.key         = $urandom;
        in_item.entry_value = $urandom;
        repeat (span - 1) @(negedge clk);
    endtask

    // Hold the sender until every expected result is back, then let the block settle
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_table_size(logic [SIZE_BITS-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        tracker.set_size(v);
    endtask

    function automatic logic [KEY_BITS-1:0] random_key();
        int unsigned pick;
        logic [KEY_BITS-1:0] k;
        pick = $urandom_range(0, 9);
        if (pick <= 2)
            k = $urandom;
        else if (pick <= 4)
        begin
            k = $urandom_range(0, 4095);
            k[KEY_BITS-1] = $urandom_range(0, 1);
        end
        else if (pick <= 7 && key_pool.size() != 0)
        begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            // Same slot, other sign
            if ($urandom_range(0, 3) == 0)
                k[KEY_BITS-1] = ~k[KEY_BITS-1];
        end
        else if (pick == 8)
            k = last_key;
        else
        begin
            case ($urandom_range(0, 4))
                0: k = 32'h0000_0000;
                1: k = 32'h7FFF_FFFF;
                2: k = 32'h8000_0000;
                3: k = 32'hFFFF_FFFF;
                default: k = tracker.live_size() * $urandom_range(0, 1000)
                             + $urandom_range(0, 1);
            endcase
        end
        return k;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // One table size, then a run of random requests; optionally pause mid-run
    task automatic run_phase(logic [SIZE_BITS-1:0] size, int count, int insert_pct,
                             int pause_at);
        in_item_t req;
        logic     kind;
        write_table_size(size);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                drain_results();
            kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_LOOKUP;
            req  = make_request(kind, random_key(), random_value());
            push_request(req);
            sender_gap();
        end
    endtask

    // Directed part, back to back so same-slot items follow each other closely
    task automatic run_directed();
        // Reset size: empty table misses, including the top slot
        push_request(make_request(KIND_LOOKUP, 32'd5, 32'h0));
        push_request(make_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        // One slot: first insert fills the table, the next is refused
        write_table_size(11'd1);
        push_request(make_request(KIND_INSERT, 32'h1234_5678, 32'hFFFF_FFFF));
        push_request(make_request(KIND_INSERT, 32'h0000_0000, 32'h0000_0000));
        push_request(make_request(KIND_LOOKUP, 32'h8000_0000, 32'h0));
        push_request(make_request(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0));

        // Zero acts as one slot
        write_table_size(11'd0);
        push_request(make_request(KIND_INSERT, 32'd3, 32'h1357_9BDF));
        push_request(make_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0));

        // Above the top acts as the full table; replacements still count
        write_table_size(11'h7FF);
        push_request(make_request(KIND_INSERT, 32'h0000_0000, 32'h0000_0000));
        push_request(make_request(KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF));
        push_request(make_request(KIND_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5));
        push_request(make_request(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0));
        push_request(make_request(KIND_INSERT, 32'd1029, 32'h5A5A_5A5A));
        push_request(make_request(KIND_LOOKUP, 32'd5, 32'h0));
        push_request(make_request(KIND_INSERT, 32'd5, 32'h0000_0001));
        push_request(make_request(KIND_LOOKUP, 32'd5, 32'h0));
        push_request(make_request(KIND_LOOKUP, 32'd1024, 32'h0));
        push_request(make_request(KIND_LOOKUP, 32'd6, 32'h0));
        push_request(make_request(KIND_LOOKUP, 32'h8000_0005, 32'h0));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        last_key  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // Let the post-reset sweep finish before touching the size register
        do
            @(posedge clk);
        while (in_stall);

        run_directed();

        // Small prime, then medium, then the full table filled to its limit
        run_phase(11'd7, 80, 50, -1);
        run_phase(11'd100, 180, 60, -1);
        run_phase(11'd1024, 950, 80, 40);
        run_phase(11'h7FF, 250, 80, -1);
        // Shrink below the fill: every insert refused, lookups rehash
        run_phase(11'd513, 90, 50, -1);

        drain_results();
        if (tracker.failures == 0 && tracker.pending_count() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/dmht_pkg.sv
rtl/dmht_ram.sv
rtl/dmht_queue.sv
rtl/dmht_front.sv
rtl/dmht_back.sv
rtl/direct_mapped_hash_table.sv
rtl/dmht_checker.sv
test/direct_mapped_hash_table_test.sv
